[src/sal_pkg.sv]
// ----------------------------------------------------------------------------
// sal_pkg
// Shared types and codes for the sorted array list: transfer payloads,
// command and status codes, and the control that runs along the cell row.
// ----------------------------------------------------------------------------
package sal_pkg;

  localparam int VAL_W = 32;
  localparam int POS_W = 6;
  localparam int ICNT_W = 7;

  localparam logic [2:0] CMD_INSERT = 3'd0;
  localparam logic [2:0] CMD_REMOVE = 3'd1;
  localparam logic [2:0] CMD_READ   = 3'd2;
  localparam logic [2:0] CMD_SORT   = 3'd3;
  localparam logic [2:0] CMD_SETFLG = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  localparam logic [1:0] OP_HOLD   = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_PLACE  = 2'd2;
  localparam logic [1:0] OP_SWAP   = 2'd3;

  typedef struct packed {
    logic [2:0]              cmd;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
    logic                    flag_bit;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] read_value;
    logic [ICNT_W-1:0]       item_count;
    logic                    sorted_now;
    logic [1:0]              status;
  } out_item_t;

  // broadcast to every cell
  typedef struct packed {
    logic [1:0]              op;
    logic                    phase;
    logic signed [VAL_W-1:0] value;
  } cell_ctrl_t;

  // where a cell stands relative to the stored list
  typedef struct packed {
    logic in_use;
    logic at_tail;
    logic past_slot;
    logic right_use;
  } cell_pos_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] elem;
    logic                    lt_left;
    logic                    hit;
  } cell_out_t;

endpackage

[src/sal_cell.sv]
// ----------------------------------------------------------------------------
// sal_cell
// One list slot: holds an element, compares it with the insert value and its
// left neighbour, and loads from the value or a neighbour as the row demands.
// ----------------------------------------------------------------------------
module sal_cell #(
  parameter int IDX = 0
) (
  input  logic                            clk,
  input  sal_pkg::cell_ctrl_t             ctrl,
  input  sal_pkg::cell_pos_t              pos,
  input  logic signed [sal_pkg::VAL_W-1:0] left_elem,
  input  logic signed [sal_pkg::VAL_W-1:0] right_elem,
  input  logic                            right_lt,
  output sal_pkg::cell_out_t              q
);

  localparam logic PAR = 1'(IDX % 2);
  localparam logic HAS_LEFT = (IDX > 0);

  logic signed [sal_pkg::VAL_W-1:0] elem_r, elem_nxt;
  logic lt_val;
  logic lt_left;
  logic right_pair;
  logic left_pair;

  assign lt_val = elem_r < ctrl.value;
  assign lt_left = elem_r < left_elem;
  assign right_pair = (PAR == ctrl.phase) && pos.right_use;
  assign left_pair = (PAR != ctrl.phase) && pos.in_use && HAS_LEFT;

  always_comb begin
    elem_nxt = elem_r;
    case (ctrl.op)
      sal_pkg::OP_APPEND: begin
        if (pos.at_tail) elem_nxt = ctrl.value;
      end
      sal_pkg::OP_PLACE: begin
        if (pos.past_slot) begin
          elem_nxt = left_elem;
        end else if ((pos.in_use && !lt_val) || pos.at_tail) begin
          elem_nxt = ctrl.value;
        end
      end
      sal_pkg::OP_SWAP: begin
        if (right_pair && right_lt) begin
          elem_nxt = right_elem;
        end else if (left_pair && lt_left) begin
          elem_nxt = left_elem;
        end
      end
      default: elem_nxt = elem_r;
    endcase
  end

  always_ff @(posedge clk) begin
    elem_r <= elem_nxt;
  end

  assign q.elem = elem_r;
  assign q.lt_left = lt_left;
  assign q.hit = pos.in_use && !lt_val;

endmodule

[src/sal_ctrl.sv]
// ----------------------------------------------------------------------------
// sal_ctrl
// Command sequencer: handshakes, element count, sorted flag, sort pass
// counter and the registered result.
// ----------------------------------------------------------------------------
module sal_ctrl #(
  parameter int CAPACITY = 64,
  localparam int CNT_W = $clog2(CAPACITY + 1)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  sal_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output sal_pkg::out_item_t               out_data,
  input  logic signed [sal_pkg::VAL_W-1:0] read_word,
  output sal_pkg::cell_ctrl_t              ctrl,
  output logic [CNT_W-1:0]                 count
);

  localparam int CMP_W = (CNT_W > sal_pkg::POS_W) ? CNT_W : sal_pkg::POS_W;
  localparam logic S_IDLE = 1'b0;
  localparam logic S_SORT = 1'b1;

  logic state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] ph_r, ph_nxt;
  logic flag_r, flag_nxt;
  logic out_valid_r, out_valid_nxt;
  sal_pkg::out_item_t out_data_r, out_data_nxt;

  logic out_free;
  logic acc;
  logic full;
  logic sort_run;
  logic sort_done;
  logic load;
  logic pos_range;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r == S_SORT) || !out_free;
  assign acc = in_valid && !in_stall;
  assign full = (count_r == CNT_W'(CAPACITY));
  assign sort_run = (state_r == S_SORT) && (ph_r != count_r);
  assign sort_done = (state_r == S_SORT) && (ph_r == count_r) && out_free;
  assign pos_range = CMP_W'(in_data.position) >= CMP_W'(count_r);

  always_comb begin
    ctrl.op = sal_pkg::OP_HOLD;
    ctrl.phase = ph_r[0];
    ctrl.value = in_data.value;
    if (acc && (in_data.cmd == sal_pkg::CMD_INSERT) && !full) begin
      ctrl.op = flag_r ? sal_pkg::OP_PLACE : sal_pkg::OP_APPEND;
    end else if (sort_run) begin
      ctrl.op = sal_pkg::OP_SWAP;
    end
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    ph_nxt = ph_r;
    flag_nxt = flag_r;
    load = 1'b0;
    out_data_nxt = out_data_r;
    out_data_nxt.read_value = '0;
    out_data_nxt.status = sal_pkg::ST_OK;

    if (acc) begin
      load = 1'b1;
      case (in_data.cmd)
        sal_pkg::CMD_INSERT: begin
          if (full) out_data_nxt.status = sal_pkg::ST_FULL;
          else count_nxt = count_r + 1'b1;
        end
        sal_pkg::CMD_REMOVE: begin
          if (count_r == '0) out_data_nxt.status = sal_pkg::ST_EMPTY;
          else count_nxt = count_r - 1'b1;
        end
        sal_pkg::CMD_READ: begin
          if (pos_range) out_data_nxt.status = sal_pkg::ST_RANGE;
          else out_data_nxt.read_value = read_word;
        end
        sal_pkg::CMD_SORT: begin
          load = 1'b0;
          state_nxt = S_SORT;
          ph_nxt = '0;
        end
        sal_pkg::CMD_SETFLG: flag_nxt = in_data.flag_bit;
        default: ;
      endcase
    end else if (sort_run) begin
      ph_nxt = ph_r + 1'b1;
    end else if (sort_done) begin
      load = 1'b1;
      state_nxt = S_IDLE;
      flag_nxt = 1'b1;
    end

    out_data_nxt.item_count = sal_pkg::ICNT_W'(count_nxt);
    out_data_nxt.sorted_now = flag_nxt;

    if (load) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      ph_r <= '0;
      flag_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ph_r <= ph_nxt;
      flag_r <= flag_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;
  assign count = count_r;

endmodule

[src/sorted_array_list.sv]
// ----------------------------------------------------------------------------
// sorted_array_list
// Fixed-capacity list of signed words with count and sorted flag, kept in a
// row of cells that shift for sorted insert and swap for transposition sort.
// ----------------------------------------------------------------------------
// Channel   Ports                          Direction
// command   in_valid, in_stall, in_data    in  (in_stall driven out)
// result    out_valid, out_stall, out_data out (out_stall driven in)
//
// Insert, remove, read and set-flag: one result per transfer.
// Sort: one odd-even transposition pass over the cell row per cycle;
// in_stall stays high until the result is registered.
// Reset clears count, sorted flag and output valid; element cells are not
// cleared. A held result stalls the command side only when it is not taken.
// ----------------------------------------------------------------------------
module sorted_array_list #(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sal_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output sal_pkg::out_item_t out_data
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int LV = $clog2(CAPACITY);
  localparam int CMP_W = (CNT_W > sal_pkg::POS_W) ? CNT_W : sal_pkg::POS_W;

  sal_pkg::cell_ctrl_t ctrl;
  logic [CNT_W-1:0] count;
  sal_pkg::cell_out_t cell_q [CAPACITY];
  sal_pkg::cell_pos_t cell_pos [CAPACITY];
  logic [CAPACITY-1:0] in_use;
  logic [CAPACITY-1:0] hit;
  logic [CAPACITY-1:0] pre [LV+1];
  logic signed [sal_pkg::VAL_W-1:0] read_word;

  sal_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .read_word(read_word),
    .ctrl     (ctrl),
    .count    (count)
  );

  // prefix OR of hits: bit i is set where cell i or an earlier cell holds the slot
  assign pre[0] = hit;
  for (genvar l = 0; l < LV; l++) begin : g_pre
    for (genvar i = 0; i < CAPACITY; i++) begin : g_bit
      if (i >= (1 << l)) begin : g_or
        assign pre[l+1][i] = pre[l][i] | pre[l][i-(1<<l)];
      end else begin : g_pass
        assign pre[l+1][i] = pre[l][i];
      end
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [sal_pkg::VAL_W-1:0] left_elem;
    logic signed [sal_pkg::VAL_W-1:0] right_elem;
    logic right_lt;

    assign in_use[i] = CNT_W'(i) < count;
    assign hit[i] = cell_q[i].hit;
    assign cell_pos[i].in_use = in_use[i];
    assign cell_pos[i].at_tail = (count == CNT_W'(i));

    if (i == 0) begin : g_first
      assign left_elem = '0;
      assign cell_pos[i].past_slot = 1'b0;
    end else begin : g_mid
      assign left_elem = cell_q[i-1].elem;
      assign cell_pos[i].past_slot = pre[LV][i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_elem = '0;
      assign right_lt = 1'b0;
      assign cell_pos[i].right_use = 1'b0;
    end else begin : g_inner
      assign right_elem = cell_q[i+1].elem;
      assign right_lt = cell_q[i+1].lt_left;
      assign cell_pos[i].right_use = CNT_W'(i + 1) < count;
    end

    sal_cell #(
      .IDX(i)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .pos       (cell_pos[i]),
      .left_elem (left_elem),
      .right_elem(right_elem),
      .right_lt  (right_lt),
      .q         (cell_q[i])
    );
  end

  always_comb begin
    read_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (CMP_W'(in_data.position) == CMP_W'(i)) read_word = read_word | cell_q[i].elem;
    end
  end

endmodule
